### sv/preemptive_priority_scheduler_unit_defines.svh
// assertion macros for the scheduler checker
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// clocked check, off while reset is applied
`define PPSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define PPSU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/ppsu_pkg.sv
package ppsu_pkg;

	// process slots
	localparam int NUM_PROCS = 4;
	localparam int IDX_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

	// field widths
	localparam int SLOT_W  = 6;
	localparam int PRIO_W  = 8;
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int PID_W   = 6;
	localparam int WAIT_W  = 24;
	localparam int TICK_W  = 24;

	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_PROCS - 1);
	localparam logic [SLOT_W:0]   SLOT_LIM = (SLOT_W + 1)'(NUM_PROCS);
	localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

	// input item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_RUN  = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic             load_slot;
		logic             run_init;
		logic             scan_step;
		logic             jump;
		logic             calc_span;
		logic             apply;
		logic             load_out;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic any_left;
		logic have_pick;
	} sts_t;

endpackage

### sv/ppsu_if.sv
// request channel: load or run items
interface ppsu_req_if;
	import ppsu_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [SLOT_W-1:0]    slot;
	logic [PRIO_W-1:0]    prio_value;
	logic [ARR_W-1:0]     arrival_tick;
	logic [BURST_W-1:0]   burst_length;

	modport source (output valid, mode, slot, prio_value, arrival_tick, burst_length,
		input ready);
	modport sink (input valid, mode, slot, prio_value, arrival_tick, burst_length,
		output ready);
endinterface

// result channel: one transfer per slot after a run
interface ppsu_rsp_if;
	import ppsu_pkg::*;

	logic              valid;
	logic              ready;
	logic [PID_W-1:0]  process_id;
	logic [WAIT_W-1:0] wait_ticks;
	logic              last_flag;

	modport source (output valid, process_id, wait_ticks, last_flag, input ready);
	modport sink (input valid, process_id, wait_ticks, last_flag, output ready);
endinterface

### sv/ppsu_datapath.sv
module ppsu_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ppsu_pkg::cmd_t               cmd,
	output ppsu_pkg::sts_t               sts,
	input  logic [ppsu_pkg::SLOT_W-1:0]  in_slot,
	input  logic [ppsu_pkg::PRIO_W-1:0]  in_prio,
	input  logic [ppsu_pkg::ARR_W-1:0]   in_arr,
	input  logic [ppsu_pkg::BURST_W-1:0] in_burst,
	output logic [ppsu_pkg::PID_W-1:0]   out_pid,
	output logic [ppsu_pkg::WAIT_W-1:0]  out_wait,
	output logic                         out_last
);
	import ppsu_pkg::*;

	// slot tables
	logic [NUM_PROCS-1:0]  valid_q;
	logic [PRIO_W-1:0]     prio_q  [NUM_PROCS];
	logic [ARR_W-1:0]      arr_q   [NUM_PROCS];
	logic [BURST_W-1:0]    burst_q [NUM_PROCS];
	logic [BURST_W-1:0]    rem_q   [NUM_PROCS];
	logic [WAIT_W-1:0]     wait_q  [NUM_PROCS];

	// simulation time and scan accumulators
	logic [TICK_W-1:0]  now_q;
	logic [IDX_W-1:0]   pick_q;
	logic [PRIO_W-1:0]  best_prio_q;
	logic [ARR_W-1:0]   best_arr_q;
	logic [BURST_W-1:0] best_rem_q;
	logic               have_pick_q;
	logic [ARR_W-1:0]   next_q;
	logic               have_next_q;
	logic               any_left_q;
	logic [BURST_W-1:0] span_q;

	// output register payload
	logic [PID_W-1:0]  pid_q;
	logic [WAIT_W-1:0] wait_out_q;
	logic              last_q;

	// scan of the selected slot
	logic               load_hit;
	logic               first;
	logic [PRIO_W-1:0]  cur_prio;
	logic [ARR_W-1:0]   cur_arr;
	logic [BURST_W-1:0] cur_rem;
	logic               cur_live;
	logic               cur_arrived;
	logic               cur_beats;
	logic               cur_next;
	logic [TICK_W-1:0]  gap;
	logic [BURST_W-1:0] span_d;

	assign load_hit    = ({1'b0, in_slot} < SLOT_LIM);
	assign first       = (cmd.idx == '0);
	assign cur_prio    = prio_q[cmd.idx];
	assign cur_arr     = arr_q[cmd.idx];
	assign cur_rem     = rem_q[cmd.idx];
	assign cur_live    = (cur_rem != '0);
	assign cur_arrived = (TICK_W'(cur_arr) <= now_q);
	assign cur_beats   = first || !have_pick_q || (cur_prio < best_prio_q) ||
		((cur_prio == best_prio_q) && (cur_arr < best_arr_q));
	assign cur_next    = first || !have_next_q || (cur_arr < next_q);

	// span until the pick finishes or the next arrival
	assign gap    = TICK_W'(next_q) - now_q;
	assign span_d = (have_next_q && (gap < TICK_W'(best_rem_q))) ?
		gap[BURST_W-1:0] : best_rem_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.load_slot && load_hit) begin
			valid_q[in_slot[IDX_W-1:0]] <= 1'b1;
		end
	end

	// per slot tables
	for (genvar i = 0; i < NUM_PROCS; i++) begin : g_slot
		logic [WAIT_W:0] wait_sum;

		assign wait_sum = {1'b0, wait_q[i]} + (WAIT_W + 1)'(span_q);

		always_ff @(posedge clk) begin
			if (cmd.load_slot && load_hit && (in_slot[IDX_W-1:0] == IDX_W'(i))) begin
				prio_q[i]  <= in_prio;
				arr_q[i]   <= in_arr;
				burst_q[i] <= in_burst;
			end
			if (cmd.run_init) begin
				rem_q[i]  <= valid_q[i] ? burst_q[i] : '0;
				wait_q[i] <= '0;
			end else if (cmd.apply) begin
				if (pick_q == IDX_W'(i)) begin
					rem_q[i] <= rem_q[i] - span_q;
				end else if ((rem_q[i] != '0) && (TICK_W'(arr_q[i]) <= now_q)) begin
					wait_q[i] <= wait_sum[WAIT_W] ? WAIT_MAX : wait_sum[WAIT_W-1:0];
				end
			end
		end
	end

	// scan accumulators and simulation time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			have_pick_q <= 1'b0;
			have_next_q <= 1'b0;
			any_left_q  <= 1'b0;
		end else begin
			if (cmd.run_init) begin
				now_q <= '0;
			end else if (cmd.jump) begin
				now_q <= TICK_W'(next_q);
			end else if (cmd.apply) begin
				now_q <= now_q + TICK_W'(span_q);
			end
			// the first slot of a scan starts the flags afresh
			if (cmd.scan_step) begin
				any_left_q  <= (any_left_q && !first) || cur_live;
				have_pick_q <= (have_pick_q && !first) ||
					(cur_live && cur_arrived && cur_beats);
				have_next_q <= (have_next_q && !first) ||
					(cur_live && !cur_arrived && cur_next);
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			if (cur_live && cur_arrived && cur_beats) begin
				pick_q      <= cmd.idx;
				best_prio_q <= cur_prio;
				best_arr_q  <= cur_arr;
				best_rem_q  <= cur_rem;
			end
			if (cur_live && !cur_arrived && cur_next) begin
				next_q <= cur_arr;
			end
		end
		if (cmd.calc_span) begin
			span_q <= span_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pid_q      <= PID_W'(cmd.idx);
			wait_out_q <= wait_q[cmd.idx];
			last_q     <= (cmd.idx == LAST_IDX);
		end
	end

	assign sts.any_left  = any_left_q;
	assign sts.have_pick = have_pick_q;
	assign out_pid       = pid_q;
	assign out_wait      = wait_out_q;
	assign out_last      = last_q;

endmodule

### sv/ppsu_ctrl.sv
module ppsu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_mode,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  ppsu_pkg::sts_t sts,
	output ppsu_pkg::cmd_t cmd
);
	import ppsu_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_APPLY  = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             out_valid_q;
	logic             req_xfer;

	assign req_ready = (state_q == ST_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.idx = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					if (req_mode == MODE_RUN) begin
						cmd.run_init = 1'b1;
						idx_d        = '0;
						state_d      = ST_SCAN;
					end else begin
						cmd.load_slot = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_DECIDE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DECIDE: begin
				idx_d = '0;
				if (!sts.any_left) begin
					state_d = ST_EMIT;
				end else if (!sts.have_pick) begin
					cmd.jump = 1'b1;
					state_d  = ST_SCAN;
				end else begin
					cmd.calc_span = 1'b1;
					state_d       = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				idx_d     = '0;
				state_d   = ST_SCAN;
			end
			ST_EMIT: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					if (idx_q == LAST_IDX) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/preemptive_priority_scheduler_unit.sv
// load item: taken while idle, a new item may follow in the next cycle
// run item: each scheduling step is one scan over all NUM_PROCS slots, a decide state and
// either an apply state or a time jump; at most about 2*NUM_PROCS+1 steps, then NUM_PROCS
// result transfers, one per cycle while the sink is ready
// the slot scan over the tables sets the run time; no new item during a run
// asynchronous active-low reset clears valid bits, controller state and output valid
module preemptive_priority_scheduler_unit (
	input logic      clk,
	input logic      arst_n,
	ppsu_req_if.sink   req,
	ppsu_rsp_if.source rsp
);
	import ppsu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller
	ppsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// tables, scan and result register
	ppsu_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_slot  (req.slot),
		.in_prio  (req.prio_value),
		.in_arr   (req.arrival_tick),
		.in_burst (req.burst_length),
		.out_pid  (rsp.process_id),
		.out_wait (rsp.wait_ticks),
		.out_last (rsp.last_flag)
	);

endmodule

### sv/ppsu_checker.sv
`include "preemptive_priority_scheduler_unit_defines.svh"

module ppsu_checker (
	input logic      clk,
	input logic      arst_n,
	ppsu_req_if.sink   req,
	ppsu_rsp_if.source rsp
);
	import ppsu_pkg::*;

	// a stalled result holds
	`PPSU_ASSERT(a_rsp_hold, rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.process_id) && $stable(rsp.wait_ticks) && $stable(rsp.last_flag), "stalled result changed")

	// a run item closes the request side
	`PPSU_ASSERT(a_run_busy, req.valid && req.ready && (req.mode == MODE_RUN) |=> !req.ready, "request taken during a run")

	// a load item keeps the request side open
	`PPSU_ASSERT(a_load_open, req.valid && req.ready && (req.mode == MODE_LOAD) |=> req.ready, "load item blocked the next item")

	// the last result belongs to the highest slot
	`PPSU_ASSERT(a_last_id, rsp.valid && rsp.last_flag |-> rsp.process_id == PID_W'(NUM_PROCS - 1), "last flag on wrong slot")

	// no result while reset is applied
	`PPSU_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !rsp.valid, "result valid in reset")

endmodule

bind preemptive_priority_scheduler_unit ppsu_checker u_ppsu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
